// ===== design/tsp_pkg.sv =====
// Shared constants, types and register map of the touch event to screen point block.
package tsp_pkg;

   // Field widths of the two channels.
   localparam int TYPE_W  = 5;
   localparam int CODE_W  = 10;
   localparam int VALUE_W = 32;
   localparam int POINT_W = 12;
   localparam int SIZE_W  = 13;

   // Configuration port.
   localparam int ADDR_W    = 5;
   localparam int REG_IDX_W = ADDR_W - 2;
   localparam logic [REG_IDX_W-1:0] REG_X_MIN   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_X_MAX   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_Y_MIN   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_Y_MAX   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_PANEL_W = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_PANEL_H = 3'd5;

   localparam logic signed [VALUE_W-1:0] X_MIN_RST   = 32'sd0;
   localparam logic signed [VALUE_W-1:0] X_MAX_RST   = 32'sd4095;
   localparam logic signed [VALUE_W-1:0] Y_MIN_RST   = 32'sd0;
   localparam logic signed [VALUE_W-1:0] Y_MAX_RST   = 32'sd4095;
   localparam logic [SIZE_W-1:0]         PANEL_W_RST = 13'd480;
   localparam logic [SIZE_W-1:0]         PANEL_H_RST = 13'd800;

   // Default logical frame of the user interface.
   localparam int UI_W_DEF = 800;
   localparam int UI_H_DEF = 480;

   // Largest value the output fields carry.
   localparam logic [SIZE_W-1:0] OUT_MAX = 13'd4095;

   // Input event codes.
   localparam logic [TYPE_W-1:0] EV_KEY         = 5'd1;
   localparam logic [TYPE_W-1:0] EV_ABS         = 5'd3;
   localparam logic [CODE_W-1:0] CODE_ABS_X     = 10'd0;
   localparam logic [CODE_W-1:0] CODE_ABS_Y     = 10'd1;
   localparam logic [CODE_W-1:0] CODE_MT_X      = 10'd53;
   localparam logic [CODE_W-1:0] CODE_MT_Y      = 10'd54;
   localparam logic [CODE_W-1:0] CODE_TRACK     = 10'd57;
   localparam logic [CODE_W-1:0] CODE_BTN_TOUCH = 10'd330;

   // Shared multiply and divide unit.
   localparam int OPA_W  = 32;
   localparam int OPB_W  = SIZE_W;
   localparam int PROD_W = OPA_W + OPB_W;
   localparam int QUOT_W = 13;
   localparam int CNT_W  = $clog2(QUOT_W);

   typedef struct packed {
      logic signed [VALUE_W-1:0] x_min;
      logic signed [VALUE_W-1:0] x_max;
      logic signed [VALUE_W-1:0] y_min;
      logic signed [VALUE_W-1:0] y_max;
      logic [SIZE_W-1:0]         panel_w;
      logic [SIZE_W-1:0]         panel_h;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [OPA_W-1:0]  op_a;
      logic [OPB_W-1:0]  op_b;
      logic [OPA_W-1:0]  op_den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== design/tsp_ifs.sv =====
// Valid/ready channel interfaces for input events and screen points.
interface tsp_req_if;
   import tsp_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [TYPE_W-1:0]         event_type;
   logic [CODE_W-1:0]         event_code;
   logic signed [VALUE_W-1:0] event_value;

   modport source (output valid, output event_type, output event_code, output event_value,
                   input ready);
   modport sink   (input valid, input event_type, input event_code, input event_value,
                   output ready);
endinterface

interface tsp_rsp_if;
   import tsp_pkg::*;
   logic               valid;
   logic               ready;
   logic [POINT_W-1:0] point_x;
   logic [POINT_W-1:0] point_y;
   logic               pressed;

   modport source (output valid, output point_x, output point_y, output pressed,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input pressed,
                   output ready);
endinterface

// ===== design/touch_event_to_screen_point_top.sv =====
// Top level: turns touch input events into calibrated, rotated screen points.
//
// Usage. Input events (type, code, signed value) arrive on req_ch, one item per
// valid/ready handshake. Position events update the stored raw X or Y, tracking-id
// and touch-button events update the pressed flag, and every other event is kept
// only as a trigger. Each accepted item produces exactly one item on rsp_ch with
// the current screen point and the pressed flag.
// Operation. One event is processed at a time and req_ch.ready is low while it is.
// Each division runs on the shared multiply and divide unit as an issue step, a
// multiply, a range check, 13 quotient bits and a result step. A landscape or
// square panel needs two divisions, a portrait panel four; once the point has gone
// to the output register the next item can be taken. Degenerate calibration ranges
// and zero panel sizes skip their division and shorten the processing of an item.
// Calibration and panel size registers are written over the APB-style port; the
// user must write them only while no item is in flight, as the block does not
// enforce it. Writes complete in the access cycle, pready is always high.
// Reset (synchronous) restores the default calibration, clears raw X, raw Y and
// the pressed flag, and drops any pending result. If the receiver stalls, the
// finished item waits in the output register while the next event is accepted
// and processed; that event's result waits until the register is free.
module touch_event_to_screen_point_top #(
   parameter int UI_W = tsp_pkg::UI_W_DEF,
   parameter int UI_H = tsp_pkg::UI_H_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   tsp_req_if.sink                     req_ch,
   tsp_rsp_if.source                   rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tsp_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import tsp_pkg::*;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_WAIT  = 2'd2;
   localparam logic [1:0] ST_OUT   = 2'd3;

   // Division jobs, in the order they run.
   localparam logic [1:0] JOB_SX = 2'd0;
   localparam logic [1:0] JOB_SY = 2'd1;
   localparam logic [1:0] JOB_LX = 2'd2;
   localparam logic [1:0] JOB_LY = 2'd3;

   localparam logic [OPB_W-1:0] UI_W_MUL = OPB_W'(UI_W);
   localparam logic [OPB_W-1:0] UI_H_MUL = OPB_W'(UI_H);
   localparam logic [OPB_W-1:0] UI_W_LIM = OPB_W'(UI_W - 1);
   localparam logic [OPB_W-1:0] UI_H_LIM = OPB_W'(UI_H - 1);

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   logic [1:0]                state_ff, state_in;
   logic [1:0]                job_ff, job_in;
   logic signed [VALUE_W-1:0] raw_x_ff, raw_x_in;
   logic signed [VALUE_W-1:0] raw_y_ff, raw_y_in;
   logic                      touch_ff, touch_in;
   logic signed [VALUE_W-1:0] sx_ff, sx_in;
   logic signed [VALUE_W-1:0] sy_ff, sy_in;
   logic [POINT_W-1:0]        lx_ff, lx_in;
   logic [POINT_W-1:0]        ly_ff, ly_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [POINT_W-1:0]        point_x_ff, point_x_in;
   logic [POINT_W-1:0]        point_y_ff, point_y_in;
   logic                      pressed_ff, pressed_in;

   // Operand selection for the current job.
   logic signed [VALUE_W-1:0] sc_raw, sc_lo, sc_hi, sc_clamped;
   logic [SIZE_W-1:0]         sc_size;
   logic signed [VALUE_W+1:0] lx_num;
   logic                      iss_bypass;
   logic signed [VALUE_W-1:0] iss_value;
   logic                      portrait;

   // Result of the current job.
   logic                      res_valid;
   logic signed [VALUE_W-1:0] res_value;
   logic [SIZE_W-1:0]         res_lim;
   logic [POINT_W-1:0]        res_ui;

   // Clamp of a scaled coordinate to a landscape panel and the output range.
   function automatic logic [POINT_W-1:0] clamp_land(input logic signed [VALUE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] bound;
      if (size == '0) begin
         bound = '0;
      end else if (size - 1'b1 > OUT_MAX) begin
         bound = OUT_MAX;
      end else begin
         bound = size - 1'b1;
      end
      if (v[VALUE_W-1]) begin
         return '0;
      end else if (v[VALUE_W-2:0] > (VALUE_W-1)'(bound)) begin
         return bound[POINT_W-1:0];
      end else begin
         return v[POINT_W-1:0];
      end
   endfunction

   tsp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tsp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.point_x = point_x_ff;
   assign rsp_ch.point_y = point_y_ff;
   assign rsp_ch.pressed = pressed_ff;

   assign portrait = cfg.panel_w < cfg.panel_h;

   // Operands of the job about to be issued. Scaling jobs compute
   // (raw - min) * (size - 1) / (max - min) on the clamped raw value; a degenerate
   // range passes the raw value through, and a zero panel size gives zero since
   // every later use of that coordinate ends at zero. The rotation jobs compute
   // (height - 1 - sy) * UI_W / height and sx * UI_H / width, where a negative
   // numerator or a zero width gives zero.
   always_comb begin
      sc_raw  = raw_x_ff;
      sc_lo   = cfg.x_min;
      sc_hi   = cfg.x_max;
      sc_size = cfg.panel_w;
      if (job_ff == JOB_SY) begin
         sc_raw  = raw_y_ff;
         sc_lo   = cfg.y_min;
         sc_hi   = cfg.y_max;
         sc_size = cfg.panel_h;
      end
      if (sc_raw < sc_lo) begin
         sc_clamped = sc_lo;
      end else if (sc_raw > sc_hi) begin
         sc_clamped = sc_hi;
      end else begin
         sc_clamped = sc_raw;
      end
      lx_num = $signed({{(VALUE_W+2-SIZE_W){1'b0}}, cfg.panel_h}) - (VALUE_W+2)'(1)
               - (VALUE_W+2)'(sy_ff);

      iss_bypass     = 1'b0;
      iss_value      = '0;
      div_req.op_a   = '0;
      div_req.op_b   = '0;
      div_req.op_den = '0;
      case (job_ff) inside
         JOB_SX, JOB_SY: begin
            div_req.op_a   = sc_clamped - sc_lo;
            div_req.op_b   = sc_size - 1'b1;
            div_req.op_den = sc_hi - sc_lo;
            if (!(sc_hi > sc_lo)) begin
               iss_bypass = 1'b1;
               iss_value  = sc_raw;
            end else if (sc_size == '0) begin
               iss_bypass = 1'b1;
            end
         end
         JOB_LX: begin
            div_req.op_a   = lx_num[OPA_W-1:0];
            div_req.op_b   = UI_W_MUL;
            div_req.op_den = {{(OPA_W-SIZE_W){1'b0}}, cfg.panel_h};
            iss_bypass     = lx_num[VALUE_W+1];
         end
         default: begin
            div_req.op_a   = sx_ff;
            div_req.op_b   = UI_H_MUL;
            div_req.op_den = {{(OPA_W-SIZE_W){1'b0}}, cfg.panel_w};
            iss_bypass     = sx_ff[VALUE_W-1] || (cfg.panel_w == '0);
         end
      endcase
      div_req.start = (state_ff == ST_ISSUE) && !iss_bypass;
   end

   // A job finishes either in its issue cycle (bypass) or when the unit is done.
   // Rotated coordinates are limited to the UI frame; a saturated quotient is
   // above any limit.
   always_comb begin
      res_valid = ((state_ff == ST_ISSUE) && iss_bypass) ||
                  ((state_ff == ST_WAIT) && div_rsp.done);
      res_value = (state_ff == ST_ISSUE) ? iss_value
                                         : {{(VALUE_W-QUOT_W){1'b0}}, div_rsp.quot};
      res_lim   = (job_ff == JOB_LX) ? UI_W_LIM : UI_H_LIM;
      res_ui    = (res_value[SIZE_W-1:0] > res_lim) ? res_lim[POINT_W-1:0]
                                                    : res_value[POINT_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      raw_x_in     = raw_x_ff;
      raw_y_in     = raw_y_ff;
      touch_in     = touch_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      lx_in        = lx_ff;
      ly_in        = ly_ff;
      point_x_in   = point_x_ff;
      point_y_in   = point_y_ff;
      pressed_in   = pressed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.event_type == EV_ABS) begin
                  if (req_ch.event_code == CODE_ABS_X || req_ch.event_code == CODE_MT_X) begin
                     raw_x_in = req_ch.event_value;
                  end else if (req_ch.event_code == CODE_ABS_Y ||
                               req_ch.event_code == CODE_MT_Y) begin
                     raw_y_in = req_ch.event_value;
                  end else if (req_ch.event_code == CODE_TRACK) begin
                     // A negative tracking id means the contact was lifted.
                     touch_in = !req_ch.event_value[VALUE_W-1];
                  end
               end else if (req_ch.event_type == EV_KEY &&
                            req_ch.event_code == CODE_BTN_TOUCH) begin
                  touch_in = (req_ch.event_value != '0);
               end
               job_in   = JOB_SX;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE, ST_WAIT: begin
            if (state_ff == ST_ISSUE && !iss_bypass) begin
               state_in = ST_WAIT;
            end
            if (res_valid) begin
               unique case (job_ff)
                  JOB_SX: begin
                     sx_in    = res_value;
                     job_in   = JOB_SY;
                     state_in = ST_ISSUE;
                  end
                  JOB_SY: begin
                     sy_in = res_value;
                     if (portrait) begin
                        job_in   = JOB_LX;
                        state_in = ST_ISSUE;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
                  JOB_LX: begin
                     lx_in    = res_ui;
                     job_in   = JOB_LY;
                     state_in = ST_ISSUE;
                  end
                  default: begin
                     ly_in    = res_ui;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         default: begin
            // Hand the point to the output register once it is free.
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               pressed_in   = touch_ff;
               if (portrait) begin
                  point_x_in = lx_ff;
                  point_y_in = ly_ff;
               end else begin
                  point_x_in = clamp_land(sx_ff, cfg.panel_w);
                  point_y_in = clamp_land(sy_ff, cfg.panel_h);
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= JOB_SX;
         raw_x_ff     <= '0;
         raw_y_ff     <= '0;
         touch_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         raw_x_ff     <= raw_x_in;
         raw_y_ff     <= raw_y_in;
         touch_ff     <= touch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      lx_ff      <= lx_in;
      ly_ff      <= ly_in;
      point_x_ff <= point_x_in;
      point_y_ff <= point_y_in;
      pressed_ff <= pressed_in;
   end

endmodule

// ===== design/tsp_csr.sv =====
// Calibration and panel size registers behind the APB-style port.
module tsp_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tsp_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready,
   output tsp_pkg::cfg_type             cfg
);
   import tsp_pkg::*;

   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;
   cfg_type              cfg_ff;
   cfg_type              cfg_in;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_X_MIN:   cfg_in.x_min   = pwdata;
            REG_X_MAX:   cfg_in.x_max   = pwdata;
            REG_Y_MIN:   cfg_in.y_min   = pwdata;
            REG_Y_MAX:   cfg_in.y_max   = pwdata;
            REG_PANEL_W: cfg_in.panel_w = pwdata[SIZE_W-1:0];
            REG_PANEL_H: cfg_in.panel_h = pwdata[SIZE_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_X_MIN:   prdata = cfg_ff.x_min;
         REG_X_MAX:   prdata = cfg_ff.x_max;
         REG_Y_MIN:   prdata = cfg_ff.y_min;
         REG_Y_MAX:   prdata = cfg_ff.y_max;
         REG_PANEL_W: prdata = {{(32-SIZE_W){1'b0}}, cfg_ff.panel_w};
         REG_PANEL_H: prdata = {{(32-SIZE_W){1'b0}}, cfg_ff.panel_h};
         default:     prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_min   <= X_MIN_RST;
         cfg_ff.x_max   <= X_MAX_RST;
         cfg_ff.y_min   <= Y_MIN_RST;
         cfg_ff.y_max   <= Y_MAX_RST;
         cfg_ff.panel_w <= PANEL_W_RST;
         cfg_ff.panel_h <= PANEL_H_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/tsp_div.sv =====
// Shared unit: one registered multiply, then a restoring divide one quotient bit per cycle.
module tsp_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tsp_pkg::div_req_type  div_req,
   output tsp_pkg::div_rsp_type  div_rsp
);
   import tsp_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MUL  = 2'd1;
   localparam logic [1:0] PH_CHK  = 2'd2;
   localparam logic [1:0] PH_RUN  = 2'd3;

   logic [1:0]        phase_ff, phase_in;
   logic [OPA_W-1:0]  opa_ff, opa_in;
   logic [OPB_W-1:0]  opb_ff, opb_in;
   logic [OPA_W-1:0]  den_ff, den_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0] dsh_ff, dsh_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [PROD_W-1:0] prod;
   logic [PROD_W-1:0] den_top;
   logic [PROD_W:0]   diff;
   logic              fits;

   assign prod    = opa_ff * opb_ff;
   assign den_top = {den_ff, {QUOT_W{1'b0}}};
   assign diff    = {1'b0, rem_ff} - {1'b0, dsh_ff};
   assign fits    = !diff[PROD_W];

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

   always_comb begin
      phase_in = phase_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      quot_in  = quot_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (div_req.start) begin
               opa_in   = div_req.op_a;
               opb_in   = div_req.op_b;
               den_in   = div_req.op_den;
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            rem_in   = prod;
            dsh_in   = {1'b0, den_ff, {(QUOT_W-1){1'b0}}};
            phase_in = PH_CHK;
         end
         PH_CHK: begin
            // A quotient that needs more bits than the unit produces saturates.
            if (rem_ff >= den_top) begin
               quot_in  = {QUOT_W{1'b1}};
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               quot_in  = '0;
               cnt_in   = CNT_W'(QUOT_W - 1);
               phase_in = PH_RUN;
            end
         end
         PH_RUN: begin
            quot_in = {quot_ff[QUOT_W-2:0], fits};
            if (fits) begin
               rem_in = diff[PROD_W-1:0];
            end
            dsh_in = dsh_ff >> 1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff  <= opa_in;
      opb_ff  <= opb_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== design/tsp_checker.sv =====
// Port-level checker for the touch event to screen point block, bound to the top level.
module tsp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tsp_pkg::POINT_W-1:0] rsp_point_x,
   input logic [tsp_pkg::POINT_W-1:0] rsp_point_y,
   input logic                        rsp_pressed,
   input logic                        psel,
   input logic                        penable,
   input logic                        pwrite,
   input logic                        pready,
   input logic [tsp_pkg::ADDR_W-1:0]  paddr,
   input logic [31:0]                 pwdata,
   input logic [31:0]                 prdata
);
   import tsp_pkg::*;

   // A stalled result keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_point_x) &&
                                  $stable(rsp_point_y) && $stable(rsp_pressed))
      else $error("stalled result changed");

   // Events are processed one at a time: ready drops after an item is taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an event is in flight");

   // Reset drops any pending result.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A write to the X minimum register reads back in full.
   assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && paddr[ADDR_W-1:2] == REG_X_MIN
      |=> paddr != $past(paddr) || prdata == $past(pwdata))
      else $error("register read-back mismatch");

endmodule

bind touch_event_to_screen_point_top tsp_checker u_tsp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_point_x (rsp_ch.point_x),
   .rsp_point_y (rsp_ch.point_y),
   .rsp_pressed (rsp_ch.pressed),
   .psel        (psel),
   .penable     (penable),
   .pwrite      (pwrite),
   .pready      (pready),
   .paddr       (paddr),
   .pwdata      (pwdata),
   .prdata      (prdata)
);

// ===== dv/tb_touch_event_to_screen_point_top.sv =====
// Self-checking testbench of the touch event to screen point block.
module tb_touch_event_to_screen_point_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tsp_pkg::*;

   // Event types and codes that the block treats as plain triggers.
   localparam logic [TYPE_W-1:0] EV_SYN          = 5'd0;
   localparam logic [TYPE_W-1:0] EV_REL          = 5'd2;
   localparam logic [TYPE_W-1:0] EV_TYPE_TOP     = 5'd31;
   localparam logic [CODE_W-1:0] CODE_SYN_REPORT = 10'd0;
   localparam logic [CODE_W-1:0] CODE_ABS_UNUSED = 10'd2;
   localparam logic [CODE_W-1:0] CODE_TOP        = 10'd1023;

   // Landscape frame that a portrait panel is rotated into.
   localparam longint FRAME_W = UI_W_DEF;
   localparam longint FRAME_H = UI_H_DEF;

   // The settle wait is longer than the slowest item takes, leaving some margin.
   localparam int SETTLE_CYCLES  = 80;
   localparam int EVENTS_PLANNED = 1550;
   localparam int PHASES         = 13;
   localparam int EVENTS_PER_PHASE = 117;
   // The receiver holds off once, long enough for the block to back up.
   localparam int HOLD_AT_EVENT  = 600;
   localparam int HOLD_CYCLES    = 400;

   typedef struct packed {
      logic [POINT_W-1:0] x;
      logic [POINT_W-1:0] y;
      logic               pressed;
   } point_type;

   // One stimulus row. Where typed is set, want holds the point read straight
   // off the behavior; otherwise the predictor supplies it.
   typedef struct packed {
      bit                  typed;
      logic [TYPE_W-1:0]   ty;
      logic [CODE_W-1:0]   code;
      logic [VALUE_W-1:0]  val;
      point_type           want;
   } stim_row_type;

   localparam int DIRECTED_N = 24;

   // The directed rows run right after reset: portrait 480 x 800 panel,
   // both calibration ranges 0 to 4095.
   localparam stim_row_type DIRECTED [DIRECTED_N] = '{
      // An ignored event still reports the point at raw (0, 0).
      '{1'b1, EV_SYN, CODE_SYN_REPORT, 32'd0,          '{12'd799, 12'd0,   1'b0}},
      '{1'b1, EV_ABS, CODE_ABS_X,      32'd4095,       '{12'd799, 12'd479, 1'b0}},
      '{1'b1, EV_ABS, CODE_ABS_Y,      32'd4095,       '{12'd0,   12'd479, 1'b0}},
      // Touch button and tracking id drive the pressed flag.
      '{1'b1, EV_KEY, CODE_BTN_TOUCH,  32'd1,          '{12'd0,   12'd479, 1'b1}},
      '{1'b1, EV_ABS, CODE_TRACK,      32'hFFFF_FFFF,  '{12'd0,   12'd479, 1'b0}},
      '{1'b1, EV_ABS, CODE_TRACK,      32'd0,          '{12'd0,   12'd479, 1'b1}},
      '{1'b1, EV_KEY, CODE_BTN_TOUCH,  32'd0,          '{12'd0,   12'd479, 1'b0}},
      // Raw values at the ends of the 32-bit range clamp to the calibration; end values also drive the pressed flag.
      '{1'b1, EV_ABS, CODE_MT_X,       32'h8000_0000,  '{12'd0,   12'd0,   1'b0}},
      '{1'b1, EV_ABS, CODE_MT_Y,       32'h8000_0000,  '{12'd799, 12'd0,   1'b0}},
      '{1'b1, EV_ABS, CODE_MT_X,       32'h7FFF_FFFF,  '{12'd799, 12'd479, 1'b0}},
      '{1'b1, EV_ABS, CODE_MT_Y,       32'h7FFF_FFFF,  '{12'd0,   12'd479, 1'b0}},
      '{1'b1, EV_KEY, CODE_BTN_TOUCH,  32'h8000_0000,  '{12'd0,   12'd479, 1'b1}},
      '{1'b1, EV_ABS, CODE_TRACK,      32'h7FFF_FFFF,  '{12'd0,   12'd479, 1'b1}},
      '{1'b1, EV_ABS, CODE_TRACK,      32'h8000_0000,  '{12'd0,   12'd479, 1'b0}},
      // Near misses of the decoded events change nothing.
      '{1'b1, EV_TYPE_TOP, CODE_TOP,   32'hFFFF_FFFF,  '{12'd0,   12'd479, 1'b0}},
      '{1'b1, EV_KEY, CODE_TRACK,      32'd1,          '{12'd0,   12'd479, 1'b0}},
      '{1'b1, EV_ABS, CODE_BTN_TOUCH,  32'd1,          '{12'd0,   12'd479, 1'b0}},
      '{1'b1, EV_ABS, CODE_ABS_UNUSED, 32'd5,          '{12'd0,   12'd479, 1'b0}},
      '{1'b1, EV_KEY, CODE_ABS_X,      32'd7,          '{12'd0,   12'd479, 1'b0}},
      // The remaining rows, mid-range points among them, go through the predictor.
      '{1'b0, EV_ABS, CODE_ABS_X,      32'd2048,       '{12'd0,   12'd0,   1'b0}},
      '{1'b0, EV_ABS, CODE_MT_Y,       32'd1000,       '{12'd0,   12'd0,   1'b0}},
      '{1'b0, EV_ABS, CODE_ABS_Y,      32'hFFFF_FFFB,  '{12'd0,   12'd0,   1'b0}},
      '{1'b0, EV_KEY, CODE_BTN_TOUCH,  32'd2,          '{12'd0,   12'd0,   1'b0}},
      '{1'b0, EV_REL, CODE_ABS_X,      32'd100,        '{12'd0,   12'd0,   1'b0}}
   };

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   tsp_req_if req_ch ();
   tsp_rsp_if rsp_ch ();

   touch_event_to_screen_point_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Shadow of the block: calibration registers, raw position and touch state.
   cfg_type                   calib;
   logic signed [VALUE_W-1:0] touch_x_raw;
   logic signed [VALUE_W-1:0] touch_y_raw;
   logic                      finger_down;

   // Points still owed by the block, oldest first.
   point_type pending_points [$];

   int mismatch_count  = 0;
   int events_accepted = 0;
   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The run never takes more than a small part of this.
   initial begin
      #10ms;
      $display("tb_touch_event_to_screen_point_top: FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Clamp to the calibration and stretch over the panel. A range whose max
   // does not lie above its min leaves the raw value as it is.
   function automatic longint scale_axis(longint v, longint lo, longint hi, longint size);
      if (hi <= lo) return v;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return (v - lo) * (size - 1) / (hi - lo);
   endfunction

   // Clamp to [0, hi], where hi itself is held within the 12-bit output range.
   function automatic logic [POINT_W-1:0] clamp_point(longint v, longint hi);
      if (hi < 0) hi = 0;
      if (hi > OUT_MAX) hi = OUT_MAX;
      if (v < 0) return '0;
      if (v > hi) return POINT_W'(hi);
      return POINT_W'(v);
   endfunction

   // Applies one event to the shadow state and returns the point it reports.
   function automatic point_type predict_point(logic [TYPE_W-1:0] ty,
                                               logic [CODE_W-1:0] code,
                                               logic signed [VALUE_W-1:0] val);
      longint pw, ph, sx, sy;
      point_type pt;
      if (ty == EV_ABS) begin
         if (code == CODE_ABS_X || code == CODE_MT_X) touch_x_raw = val;
         else if (code == CODE_ABS_Y || code == CODE_MT_Y) touch_y_raw = val;
         else if (code == CODE_TRACK) finger_down = (val >= 0);
      end else if (ty == EV_KEY && code == CODE_BTN_TOUCH) begin
         finger_down = (val != 0);
      end
      pw = calib.panel_w;
      ph = calib.panel_h;
      sx = scale_axis(touch_x_raw, $signed(calib.x_min), $signed(calib.x_max), pw);
      sy = scale_axis(touch_y_raw, $signed(calib.y_min), $signed(calib.y_max), ph);
      if (pw < ph) begin
         // Portrait: rotate a quarter turn into the landscape frame.
         pt.x = clamp_point((ph == 0) ? 0 : (ph - 1 - sy) * FRAME_W / ph, FRAME_W - 1);
         pt.y = clamp_point((pw == 0) ? 0 : sx * FRAME_H / pw, FRAME_H - 1);
      end else begin
         pt.x = clamp_point(sx, pw - 1);
         pt.y = clamp_point(sy, ph - 1);
      end
      pt.pressed = finger_down;
      return pt;
   endfunction

   function automatic stim_row_type plain_event(logic [TYPE_W-1:0] ty,
                                                logic [CODE_W-1:0] code,
                                                logic [VALUE_W-1:0] val);
      stim_row_type row;
      row = '0;
      row.ty   = ty;
      row.code = code;
      row.val  = val;
      return row;
   endfunction

   // Offers one item, starting at a falling edge and returning at one. The
   // valid line is written once per step: lowered only when a gap follows.
   task automatic send_event(input stim_row_type row);
      point_type want;
      // Idle pattern by progress: receiver-heavy gaps, then sender-heavy, then none.
      if (events_accepted < EVENTS_PLANNED / 3) begin
         send_idle_pct = 20;
         recv_idle_pct = 48;
      end else if (events_accepted < 2 * EVENTS_PLANNED / 3) begin
         send_idle_pct = 48;
         recv_idle_pct = 20;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid       <= 1'b1;
      req_ch.event_type  <= row.ty;
      req_ch.event_code  <= row.code;
      req_ch.event_value <= row.val;
      do @(posedge clock); while (!req_ch.ready);
      want = predict_point(row.ty, row.code, row.val);
      if (row.typed) want = row.want;
      pending_points.push_back(want);
      events_accepted++;
      @(negedge clock);
   endtask

   // Waits until every point is in and the block has settled; ends at a falling edge.
   task automatic wait_idle();
      while (pending_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // One APB write: setup step, access step, written at the edge with pready.
   // psel stays high between back-to-back writes; the caller drops it.
   task automatic write_csr(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_X_MIN:   calib.x_min   = data;
         REG_X_MAX:   calib.x_max   = data;
         REG_Y_MIN:   calib.y_min   = data;
         REG_Y_MAX:   calib.y_max   = data;
         REG_PANEL_W: calib.panel_w = data[SIZE_W-1:0];
         REG_PANEL_H: calib.panel_h = data[SIZE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_calibration(input logic [31:0] x_lo, input logic [31:0] x_hi,
                                  input logic [31:0] y_lo, input logic [31:0] y_hi,
                                  input logic [31:0] pw_word, input logic [31:0] ph_word);
      write_csr(REG_X_MIN, x_lo);
      write_csr(REG_X_MAX, x_hi);
      write_csr(REG_Y_MIN, y_lo);
      write_csr(REG_Y_MAX, y_hi);
      write_csr(REG_PANEL_W, pw_word);
      write_csr(REG_PANEL_H, ph_word);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Panel sizes: mostly in the legal span, with zero and the 13-bit top now and then.
   // Upper bits of the written word are junk that the register must drop.
   function automatic logic [31:0] pick_panel_word();
      logic [31:0] w;
      w = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
      case ($urandom_range(0, 9))
         0:       w[SIZE_W-1:0] = '0;
         1:       w[SIZE_W-1:0] = '1;
         2:       w[SIZE_W-1:0] = 13'd4096;
         3:       w[SIZE_W-1:0] = 13'd1;
         default: w[SIZE_W-1:0] = SIZE_W'($urandom_range(1, 4096));
      endcase
      return w;
   endfunction

   function automatic logic [31:0] pick_bound();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $urandom_range(0, 4000) - 2000;
   endfunction

   // Calibration of each phase. Phase 0 keeps the reset values.
   task automatic apply_setting(input int phase);
      logic [31:0] x_lo, y_lo;
      case (phase)
         1: set_calibration(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd4095, 32'd4096, 32'd1);
         2: set_calibration(32'd100, 32'd100, 32'd500, -32'sd500, 32'd1, 32'd4096);
         3: set_calibration(32'd0, 32'd4095, -32'sd4095, 32'd0, 32'd0, 32'd4096);
         4: set_calibration(-32'sd1000, 32'd1000, 32'h8000_0000, 32'h8000_0001,
                            32'd8191, 32'd0);
         5: set_calibration(-32'sd10, 32'd10, 32'd0, 32'd1, 32'd800, 32'd800);
         6: set_calibration(32'd0, 32'd4095, 32'd0, 32'd4095, 32'd0, 32'd0);
         12: set_calibration(X_MIN_RST, X_MAX_RST, Y_MIN_RST, Y_MAX_RST,
                             32'(PANEL_W_RST), 32'(PANEL_H_RST));
         default: begin
            // Random ranges, now and then reversed or flat.
            x_lo = pick_bound();
            y_lo = pick_bound();
            set_calibration(x_lo, x_lo + $urandom_range(0, 6000) - 500,
                            y_lo, y_lo + $urandom_range(0, 6000) - 500,
                            pick_panel_word(), pick_panel_word());
         end
      endcase
   endtask

   // Raw coordinate aimed at the current range: inside it mostly, at its
   // ends, just outside it, or anywhere in 32 bits.
   function automatic logic [31:0] pick_coord(longint lo, longint hi);
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'(lo);
         2: return 32'(hi);
         3: return 32'(lo - $urandom_range(1, 50));
         4: return 32'(hi + $urandom_range(1, 50));
         default: begin
            if (hi > lo) return 32'(lo + longint'(r % (hi - lo + 1)));
            return 32'(lo + $urandom_range(0, 40) - 20);
         end
      endcase
   endfunction

   // Mostly complete touch strokes (down, moves with sync, up) with random
   // content; the rest is noise and broken strokes.
   task automatic run_touch_traffic(input int quota);
      int goal, moves;
      logic [CODE_W-1:0] x_code, y_code;
      goal = events_accepted + quota;
      while (events_accepted < goal) begin
         if ($urandom_range(0, 9) < 2) begin
            case ($urandom_range(0, 3))
               0: send_event(plain_event(TYPE_W'($urandom_range(0, 31)),
                                         CODE_W'($urandom_range(0, 1023)), $urandom));
               1: send_event(plain_event(EV_ABS, CODE_W'($urandom_range(0, 63)), $urandom));
               2: send_event(plain_event(EV_KEY, CODE_BTN_TOUCH, $urandom));
               default: send_event(plain_event(EV_ABS, CODE_TRACK, $urandom));
            endcase
         end else begin
            x_code = $urandom_range(0, 1) ? CODE_MT_X : CODE_ABS_X;
            y_code = $urandom_range(0, 1) ? CODE_MT_Y : CODE_ABS_Y;
            if ($urandom_range(0, 1))
               send_event(plain_event(EV_ABS, CODE_TRACK, $urandom_range(0, 65535)));
            else
               send_event(plain_event(EV_KEY, CODE_BTN_TOUCH, 32'd1));
            moves = $urandom_range(1, 6);
            repeat (moves) begin
               if ($urandom_range(0, 4) != 0)
                  send_event(plain_event(EV_ABS, x_code,
                                         pick_coord($signed(calib.x_min), $signed(calib.x_max))));
               if ($urandom_range(0, 4) != 0)
                  send_event(plain_event(EV_ABS, y_code,
                                         pick_coord($signed(calib.y_min), $signed(calib.y_max))));
               send_event(plain_event(EV_SYN, CODE_SYN_REPORT, 32'd0));
            end
            if ($urandom_range(0, 1))
               send_event(plain_event(EV_ABS, CODE_TRACK, 32'hFFFF_FFFF));
            else
               send_event(plain_event(EV_KEY, CODE_BTN_TOUCH, 32'd0));
         end
      end
   endtask

   // Receiver: ready changes at falling edges. Once, mid-run, it holds off for
   // a long stretch so that the output register fills and the input stalls.
   initial begin
      bit held_off;
      held_off     = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && events_accepted >= HOLD_AT_EVENT) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ch.ready <= !reset && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Checker: every point taken at a rising edge is matched against the
   // oldest one still owed, field by field.
   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_points.size() == 0) begin
            report_mismatch("point with no event pending", rsp_ch.point_x, -1);
         end else begin
            want = pending_points.pop_front();
            if (rsp_ch.point_x !== want.x)
               report_mismatch("point_x", rsp_ch.point_x, want.x);
            if (rsp_ch.point_y !== want.y)
               report_mismatch("point_y", rsp_ch.point_y, want.y);
            if (rsp_ch.pressed !== want.pressed)
               report_mismatch("pressed", rsp_ch.pressed, want.pressed);
         end
      end
   end

   // Main sequence: reset, directed rows, then one random phase per
   // calibration setting, each after the first started only once the block is idle.
   initial begin
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.event_type  = '0;
      req_ch.event_code  = '0;
      req_ch.event_value = '0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      calib.x_min        = X_MIN_RST;
      calib.x_max        = X_MAX_RST;
      calib.y_min        = Y_MIN_RST;
      calib.y_max        = Y_MAX_RST;
      calib.panel_w      = PANEL_W_RST;
      calib.panel_h      = PANEL_H_RST;
      touch_x_raw        = '0;
      touch_y_raw        = '0;
      finger_down        = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_N; i++) send_event(DIRECTED[i]);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            // The current valid stays low through the register writes.
            req_ch.valid <= 1'b0;
            wait_idle();
            apply_setting(phase);
         end
         run_touch_traffic(EVENTS_PER_PHASE);
      end
      req_ch.valid <= 1'b0;
      wait_idle();

      if (mismatch_count == 0)
         $display("tb_touch_event_to_screen_point_top: PASS");
      else
         $display("tb_touch_event_to_screen_point_top: FAIL");
      $finish;
   end

endmodule
